// ===== hw/rtl/tss_pkg.sv =====
package tss_pkg;

    localparam int unsigned COORD_WIDTH_DEF = 10;
    localparam int unsigned COLOR_WIDTH     = 16;

endpackage

// ===== hw/rtl/tss_edge_div.sv =====
module tss_edge_div #(
    parameter int unsigned CW = tss_pkg::COORD_WIDTH_DEF,
    parameter int unsigned TW = 8
) (
    input  logic                  i_clk,
    input  logic                  i_adv,
    input  logic                  i_neg,
    input  logic [2*CW-1:0]       i_num,
    input  logic [CW:0]           i_den,
    input  logic [TW-1:0]         i_tag,
    output logic                  o_neg,
    output logic [2*CW-1:0]       o_quo,
    output logic [TW-1:0]         o_tag
);
    // Restoring divider, one quotient bit per stage, on magnitudes.
    localparam int unsigned NW = 2 * CW;
    localparam int unsigned RW = CW + 2;

    logic [NW-1:0] r_num [1:NW];
    logic [RW-1:0] r_rem [1:NW];
    logic [CW:0]   r_den [1:NW];
    logic          r_neg [1:NW];
    logic [TW-1:0] r_tag [1:NW];

    for (genvar k = 0; k < NW; k++) begin : g_st
        logic [NW-1:0] n_num;
        logic [RW-1:0] n_rem;
        logic [CW:0]   n_den;
        logic          n_neg;
        logic [TW-1:0] n_tag;
        logic [RW-1:0] n_sh;
        logic [RW-1:0] n_diff;
        logic          n_ge;
        if (k == 0) begin : g_in
            assign n_num = i_num;
            assign n_rem = '0;
            assign n_den = i_den;
            assign n_neg = i_neg;
            assign n_tag = i_tag;
        end else begin : g_mid
            assign n_num = r_num[k];
            assign n_rem = r_rem[k];
            assign n_den = r_den[k];
            assign n_neg = r_neg[k];
            assign n_tag = r_tag[k];
        end
        always_comb begin
            n_sh   = {n_rem[RW-2:0], n_num[NW-1]};
            n_diff = n_sh - RW'(n_den);
            n_ge   = n_sh >= RW'(n_den);
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k+1] <= n_ge ? n_diff : n_sh;
                r_num[k+1] <= {n_num[NW-2:0], n_ge};
                r_den[k+1] <= n_den;
                r_neg[k+1] <= n_neg;
                r_tag[k+1] <= n_tag;
            end
        end
    end

    assign o_neg = r_neg[NW];
    assign o_quo = r_num[NW];
    assign o_tag = r_tag[NW];
endmodule

// ===== hw/rtl/triangle_scanline_span.sv =====
// Registered path: sort stage, edge setup, magnitude products, the edge dividers, output register.
// Throughput: one transaction per cycle; the edge dividers are fully pipelined,
// one quotient bit per stage, and the whole pipeline advances when not stalled.
// Reset (i_rst_n low, synchronous) clears every stage valid bit; data registers
// are not reset.
module triangle_scanline_span #(
    parameter int unsigned COORD_WIDTH = tss_pkg::COORD_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [COORD_WIDTH-1:0]             i_vert_a_x,
    input  logic [COORD_WIDTH-1:0]             i_vert_a_y,
    input  logic [COORD_WIDTH-1:0]             i_vert_b_x,
    input  logic [COORD_WIDTH-1:0]             i_vert_b_y,
    input  logic [COORD_WIDTH-1:0]             i_vert_c_x,
    input  logic [COORD_WIDTH-1:0]             i_vert_c_y,
    input  logic [tss_pkg::COLOR_WIDTH-1:0]    i_fill_color,
    input  logic [COORD_WIDTH-1:0]             i_row,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_span_valid,
    output logic [COORD_WIDTH-1:0]             o_span_left,
    output logic [COORD_WIDTH-1:0]             o_span_right,
    output logic [COORD_WIDTH-1:0]             o_span_row,
    output logic [tss_pkg::COLOR_WIDTH-1:0]    o_span_color
);
    import tss_pkg::*;

    localparam int unsigned CW    = COORD_WIDTH;
    localparam int unsigned NW    = 2 * CW;
    localparam int unsigned DEPTH = NW + 4;
    // Tag through the first divider carries: span valid, row, colour, xa start.
    localparam int unsigned TWA   = 1 + CW + COLOR_WIDTH + CW;
    // Tag through the second divider carries xb start.
    localparam int unsigned TWB   = CW;

    // The pipeline stalls as a whole; the output register is the last stage.
    logic adv;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    logic [DEPTH-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    // Stage 1: sort network.
    logic [CW-1:0] n_x1, n_y1, n_x2, n_y2, n_x3, n_y3, n_sw;
    always_comb begin
        n_sw = '0;
        n_x1 = i_vert_a_x; n_y1 = i_vert_a_y;
        n_x2 = i_vert_b_x; n_y2 = i_vert_b_y;
        n_x3 = i_vert_c_x; n_y3 = i_vert_c_y;
        if (n_y1 > n_y2) begin
            n_sw = n_y1; n_y1 = n_y2; n_y2 = n_sw;
            n_sw = n_x1; n_x1 = n_x2; n_x2 = n_sw;
        end
        if (n_y2 > n_y3) begin
            n_sw = n_y2; n_y2 = n_y3; n_y3 = n_sw;
            n_sw = n_x2; n_x2 = n_x3; n_x3 = n_sw;
        end
        if (n_y1 > n_y2) begin
            n_sw = n_y1; n_y1 = n_y2; n_y2 = n_sw;
            n_sw = n_x1; n_x1 = n_x2; n_x2 = n_sw;
        end
    end

    logic [CW-1:0] r1_x1, r1_y1, r1_x2, r1_y2, r1_x3, r1_y3, r1_row;
    logic [COLOR_WIDTH-1:0] r1_col;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_x1 <= n_x1; r1_y1 <= n_y1; r1_x2 <= n_x2; r1_y2 <= n_y2;
            r1_x3 <= n_x3; r1_y3 <= n_y3; r1_row <= i_row; r1_col <= i_fill_color;
        end
    end

    // Stage 2: pick edges and form signed differences.
    logic          n2_sv, n2_up;
    logic [CW-1:0] n2_xas, n2_xae, n2_yas, n2_yae;
    always_comb begin
        n2_sv  = (r1_y1 != r1_y3) && (r1_row >= r1_y1) && (r1_row <= r1_y3);
        n2_up  = r1_row <= r1_y2;
        n2_xas = n2_up ? r1_x1 : r1_x2;
        n2_xae = n2_up ? r1_x2 : r1_x3;
        n2_yas = n2_up ? r1_y1 : r1_y2;
        n2_yae = n2_up ? r1_y2 : r1_y3;
    end

    logic            r2_sv;
    logic [CW-1:0]   r2_row, r2_xas, r2_xbs;
    logic [COLOR_WIDTH-1:0] r2_col;
    logic signed [CW:0] r2_dxa, r2_dxb;
    logic [CW-1:0]   r2_ta, r2_tb;
    logic [CW:0]     r2_dena, r2_denb;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_sv   <= n2_sv;
            r2_row  <= r1_row;
            r2_col  <= r1_col;
            r2_xas  <= n2_xas;
            r2_xbs  <= r1_x1;
            r2_dxa  <= $signed({1'b0, n2_xae}) - $signed({1'b0, n2_xas});
            r2_dxb  <= $signed({1'b0, r1_x3}) - $signed({1'b0, r1_x1});
            // Only meaningful when the span is valid, where row >= start y.
            r2_ta   <= r1_row - n2_yas;
            r2_tb   <= r1_row - r1_y1;
            r2_dena <= {1'b0, n2_yae - n2_yas} + (CW+1)'(1);
            r2_denb <= {1'b0, r1_y3 - r1_y1} + (CW+1)'(1);
        end
    end

    // Stage 3: magnitude products.
    logic [CW:0] n3_ma, n3_mb;
    assign n3_ma = r2_dxa[CW] ? (CW+1)'(-r2_dxa) : (CW+1)'(r2_dxa);
    assign n3_mb = r2_dxb[CW] ? (CW+1)'(-r2_dxb) : (CW+1)'(r2_dxb);

    logic [NW-1:0]  r3_pa, r3_pb;
    logic           r3_na, r3_nb;
    logic [CW:0]    r3_dena, r3_denb;
    logic [TWA-1:0] r3_tag_a;
    logic [TWB-1:0] r3_tag_b;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // |dx| * t stays below 2^(2*CW) since t < 2^CW and |dx| < 2^CW.
            r3_pa    <= NW'(n3_ma) * NW'(r2_ta);
            r3_pb    <= NW'(n3_mb) * NW'(r2_tb);
            r3_na    <= r2_dxa[CW];
            r3_nb    <= r2_dxb[CW];
            r3_dena  <= r2_dena;
            r3_denb  <= r2_denb;
            r3_tag_a <= {r2_sv, r2_row, r2_col, r2_xas};
            r3_tag_b <= r2_xbs;
        end
    end

    logic           qa_neg, qb_neg;
    logic [NW-1:0]  qa, qb;
    logic [TWA-1:0] qa_tag;
    logic [TWB-1:0] qb_tag;

    tss_edge_div #(.CW(CW), .TW(TWA)) u_div_a (
        .i_clk(i_clk), .i_adv(adv), .i_neg(r3_na), .i_num(r3_pa), .i_den(r3_dena),
        .i_tag(r3_tag_a), .o_neg(qa_neg), .o_quo(qa), .o_tag(qa_tag)
    );
    tss_edge_div #(.CW(CW), .TW(TWB)) u_div_b (
        .i_clk(i_clk), .i_adv(adv), .i_neg(r3_nb), .i_num(r3_pb), .i_den(r3_denb),
        .i_tag(r3_tag_b), .o_neg(qb_neg), .o_quo(qb), .o_tag(qb_tag)
    );

    // Final stage: apply signs, add start x, order the pair (zeroed when the span is not valid).
    logic                    f_sv;
    logic [CW-1:0]           f_row, f_xas, f_xbs;
    logic [COLOR_WIDTH-1:0]  f_col;
    logic [CW-1:0]           n_a, n_b, qa_s, qb_s;
    always_comb begin
        {f_sv, f_row, f_col, f_xas} = qa_tag;
        f_xbs = qb_tag;
        // The true result lies within the edge's x range, so modular arithmetic
        // at coordinate width is exact.
        qa_s = qa_neg ? CW'(-qa) : CW'(qa);
        qb_s = qb_neg ? CW'(-qb) : CW'(qb);
        n_a  = f_xas + qa_s;
        n_b  = f_xbs + qb_s;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_span_valid <= f_sv;
            o_span_row   <= f_row;
            o_span_color <= f_col;
            if (!f_sv) begin
                o_span_left  <= '0;
                o_span_right <= '0;
            end else if (n_a > n_b) begin
                o_span_left  <= n_b;
                o_span_right <= n_a;
            end else begin
                o_span_left  <= n_a;
                o_span_right <= n_b;
            end
        end
    end

    assign o_valid = r_vld[DEPTH-1];
endmodule
